// ===== rtl/hc3_pkg.sv =====
// Shared types, constants and mod-26 helper functions for the 3x3 Hill cipher.
// No dependencies; used by every module of the block.
`default_nettype none

package hc3_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned KEY_ROW_W = 3 * LETTER_W;
  localparam int unsigned MOD_BASE = 26;
  localparam int unsigned MOD_SQ = MOD_BASE * MOD_BASE;
  // floor(2^16 / 26) + 1, exact quotient for every value below 2048
  localparam int unsigned RECIP_MUL = (65536 / MOD_BASE) + 1;

  // Key row reset values: identity matrix
  localparam logic [KEY_ROW_W-1:0] KEY_ROW0_RST = 15'd1;
  localparam logic [KEY_ROW_W-1:0] KEY_ROW1_RST = 15'd32;
  localparam logic [KEY_ROW_W-1:0] KEY_ROW2_RST = 15'd1024;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_ROW0 = 2'd0;
  localparam logic [1:0] REG_KEY_ROW1 = 2'd1;
  localparam logic [1:0] REG_KEY_ROW2 = 2'd2;

  // Action codes
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [2:0] vec_t;        // vec[c]
  typedef vec_t [2:0] mat_t;           // mat[r][c]
  typedef logic [KEY_ROW_W-1:0] key_row_t;

  // Word handed from the inverse-key pipeline to the matrix-vector stage
  typedef struct packed {
    logic    valid;
    logic    singular;
    mat_t    mat;
    vec_t    vec;
  } hc3_mat_word_t;

  // x mod 26 for x < 2048, by reciprocal multiply
  function automatic letter_t mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [10:0] qm;
    logic [10:0] r;
    prod = 23'(x) * 23'(RECIP_MUL);
    q    = prod[22:16];
    qm   = 11'(q) * 11'(MOD_BASE);
    r    = x - qm;
    return r[LETTER_W-1:0];
  endfunction

  // 5-bit value reduced into 0..25
  function automatic letter_t red26(input letter_t x);
    letter_t r;
    r = (x >= letter_t'(MOD_BASE)) ? x - letter_t'(MOD_BASE) : x;
    return r;
  endfunction

  // (a*b - c*d) mod 26, operands in 0..25
  function automatic letter_t det2(input letter_t a, input letter_t b,
                                   input letter_t c, input letter_t d);
    logic [10:0] s;
    s = 11'(a) * 11'(b) + 11'(MOD_SQ) - 11'(c) * 11'(d);
    return mod26(s);
  endfunction

  // (26 - x) mod 26
  function automatic letter_t neg26(input letter_t x);
    letter_t r;
    r = (x == '0) ? '0 : letter_t'(MOD_BASE) - x;
    return r;
  endfunction

  // Multiplicative inverse mod 26; zero where none exists
  function automatic letter_t inv26(input letter_t x);
    letter_t r;
    unique case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hill_cipher_3x3_mod26_top.sv =====
// Top level of the 3x3 mod-26 Hill cipher block.
// Depends on hc3_pkg, hc3_cfg_regs, hc3_inv_pipe and hc3_matvec.
//
// One word (action plus three letters) is taken on every cycle that start_i
// is high; busy_o stays low, so there is never back-pressure on the command
// side. Each word gives one result, shown for one cycle with out_valid_o high;
// the four register stages are letter reduction with the adjugate, the
// determinant inverse, the matrix select, and the matrix-vector product.
// The receiver cannot stall, and results are never held. Decrypt with a key
// whose determinant shares a factor with 26 gives zero letters and
// key_singular_o high. Key rows are written through the cfg port (always
// ready) and must only change while no word is in flight.
`default_nettype none

module hill_cipher_3x3_mod26_top (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  // command side
  input  wire  logic start_i,
  output       logic busy_o,
  input  wire  logic action_i,
  input  wire  logic [4:0] letter_first_i,
  input  wire  logic [4:0] letter_second_i,
  input  wire  logic [4:0] letter_third_i,
  // result side
  output       logic out_valid_o,
  output       logic [4:0] out_first_o,
  output       logic [4:0] out_second_o,
  output       logic [4:0] out_third_o,
  output       logic key_singular_o,
  // configuration write channel
  input  wire  logic cfg_valid_i,
  output       logic cfg_ready_o,
  input  wire  logic [1:0] cfg_index_i,
  input  wire  logic [14:0] cfg_data_i
);
  import hc3_pkg::*;

  mat_t          key;
  vec_t          letters;
  vec_t          result;
  hc3_mat_word_t mat_word;
  logic          accept;

  // Fully pipelined: always ready for a new word
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign letters[0] = letter_first_i;
  assign letters[1] = letter_second_i;
  assign letters[2] = letter_third_i;

  hc3_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  hc3_inv_pipe u_inv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .action_i   (action_i),
    .letters_i  (letters),
    .key_i      (key),
    .word_o     (mat_word)
  );

  hc3_matvec u_mv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (mat_word),
    .out_valid_o (out_valid_o),
    .result_o    (result),
    .singular_o  (key_singular_o)
  );

  assign out_first_o  = result[0];
  assign out_second_o = result[1];
  assign out_third_o  = result[2];

endmodule

`default_nettype wire

// ===== rtl/hc3_cfg_regs.sv =====
// Key configuration registers with the key matrix reduced mod 26.
// Depends on hc3_pkg.
`default_nettype none

module hc3_cfg_regs (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic cfg_valid_i,
  output                     logic cfg_ready_o,
  input  wire                logic [1:0] cfg_index_i,
  input  wire hc3_pkg::key_row_t     cfg_data_i,
  output      hc3_pkg::mat_t         key_o
);
  import hc3_pkg::*;

  key_row_t row0_q, row0_d;
  key_row_t row1_q, row1_d;
  key_row_t row2_q, row2_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register write decode; index 3 is ignored
  always_comb begin
    row0_d = row0_q;
    row1_d = row1_q;
    row2_d = row2_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_ROW0: row0_d = cfg_data_i;
        REG_KEY_ROW1: row1_d = cfg_data_i;
        REG_KEY_ROW2: row2_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= KEY_ROW0_RST;
      row1_q <= KEY_ROW1_RST;
      row2_q <= KEY_ROW2_RST;
    end else begin
      row0_q <= row0_d;
      row1_q <= row1_d;
      row2_q <= row2_d;
    end
  end

  // Unpack entries, column 0 in the low bits, and fold 26..31 down
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      key_o[0][c] = red26(row0_q[c*LETTER_W +: LETTER_W]);
      key_o[1][c] = red26(row1_q[c*LETTER_W +: LETTER_W]);
      key_o[2][c] = red26(row2_q[c*LETTER_W +: LETTER_W]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hc3_inv_pipe.sv =====
// Three-stage front pipeline: letter reduction, adjugate, determinant inverse,
// and selection of the key or inverse key per word. Depends on hc3_pkg.
`default_nettype none

module hc3_inv_pipe (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  input  wire                logic action_i,
  input  wire hc3_pkg::vec_t         letters_i,
  input  wire hc3_pkg::mat_t         key_i,
  output      hc3_pkg::hc3_mat_word_t word_o
);
  import hc3_pkg::*;

  // Stage 1: reduced letters and adjugate
  logic  s1_valid_q;
  logic  s1_act_q;
  vec_t  s1_vec_q, s1_vec_d;
  mat_t  s1_adj_q, s1_adj_d;

  // Stage 2: determinant inverse
  logic    s2_valid_q;
  logic    s2_act_q;
  vec_t    s2_vec_q;
  mat_t    s2_adj_q;
  letter_t s2_dinv_q, s2_dinv_d;

  // Stage 3: chosen matrix
  hc3_mat_word_t s3_q, s3_d;

  logic [10:0] det_sum;

  // Stage 1 logic: the user must keep the key stable while any word is in flight; the block does not enforce it
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s1_vec_d[c] = red26(letters_i[c]);
    end
    s1_adj_d[0][0] = det2(key_i[1][1], key_i[2][2], key_i[1][2], key_i[2][1]);
    s1_adj_d[0][1] = neg26(det2(key_i[0][1], key_i[2][2], key_i[0][2], key_i[2][1]));
    s1_adj_d[0][2] = det2(key_i[0][1], key_i[1][2], key_i[0][2], key_i[1][1]);
    s1_adj_d[1][0] = neg26(det2(key_i[1][0], key_i[2][2], key_i[1][2], key_i[2][0]));
    s1_adj_d[1][1] = det2(key_i[0][0], key_i[2][2], key_i[0][2], key_i[2][0]);
    s1_adj_d[1][2] = neg26(det2(key_i[0][0], key_i[1][2], key_i[0][2], key_i[1][0]));
    s1_adj_d[2][0] = det2(key_i[1][0], key_i[2][1], key_i[1][1], key_i[2][0]);
    s1_adj_d[2][1] = neg26(det2(key_i[0][0], key_i[2][1], key_i[0][1], key_i[2][0]));
    s1_adj_d[2][2] = det2(key_i[0][0], key_i[1][1], key_i[0][1], key_i[1][0]);
  end

  // Stage 2 logic: determinant by first-row expansion, then its inverse
  always_comb begin
    det_sum = 11'(key_i[0][0]) * 11'(s1_adj_q[0][0])
            + 11'(key_i[0][1]) * 11'(s1_adj_q[1][0])
            + 11'(key_i[0][2]) * 11'(s1_adj_q[2][0]);
    s2_dinv_d = inv26(mod26(det_sum));
  end

  // Stage 3 logic: key for encrypt, adjugate scaled by the inverse for decrypt
  always_comb begin
    s3_d.valid    = s2_valid_q;
    s3_d.singular = (s2_act_q == ACT_DECRYPT) && (s2_dinv_q == '0);
    s3_d.vec      = s2_vec_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s2_act_q == ACT_DECRYPT) begin
          s3_d.mat[r][c] = mod26(11'(s2_adj_q[r][c]) * 11'(s2_dinv_q));
        end else begin
          s3_d.mat[r][c] = key_i[r][c];
        end
      end
    end
  end

  // Valid bits, and the whole stage 3 word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_q        <= '0;
    end else begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_q        <= s3_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_act_q      <= action_i;
    s1_vec_q      <= s1_vec_d;
    s1_adj_q      <= s1_adj_d;
    s2_act_q      <= s1_act_q;
    s2_vec_q      <= s1_vec_q;
    s2_adj_q      <= s1_adj_q;
    s2_dinv_q     <= s2_dinv_d;
  end

  assign word_o = s3_q;

endmodule

`default_nettype wire

// ===== rtl/hc3_matvec.sv =====
// Final stage: matrix times letter vector mod 26, singular masking,
// registered result ports. Depends on hc3_pkg.
`default_nettype none

module hc3_matvec (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire hc3_pkg::hc3_mat_word_t word_i,
  output                     logic out_valid_o,
  output      hc3_pkg::vec_t         result_o,
  output                     logic singular_o
);
  import hc3_pkg::*;

  logic valid_q;
  vec_t res_q, res_d;
  logic sing_q;

  logic [10:0] row_sum [3];

  // One dot product per row, independent of each other
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 11'(word_i.mat[r][0]) * 11'(word_i.vec[0])
                 + 11'(word_i.mat[r][1]) * 11'(word_i.vec[1])
                 + 11'(word_i.mat[r][2]) * 11'(word_i.vec[2]);
      res_d[r]   = word_i.singular ? '0 : mod26(row_sum[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    sing_q <= word_i.singular;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;
  assign singular_o  = sing_q;

endmodule

`default_nettype wire
